[sv/dls_pkg.sv]
// ----------------------------------------------------------------------------
// dls_pkg: shared types and codes for the decode loop sequencer
// Event kinds, result codes, action codes and the flag bundle.
// ----------------------------------------------------------------------------
package dls_pkg;

    // Event kind carried with each input item.
    typedef logic [2:0] dls_cmd_t;
    localparam dls_cmd_t CMD_POLL    = 3'd0;
    localparam dls_cmd_t CMD_RECV    = 3'd1;
    localparam dls_cmd_t CMD_DEMUX   = 3'd2;
    localparam dls_cmd_t CMD_PKT     = 3'd3;
    localparam dls_cmd_t CMD_FLUSH   = 3'd4;
    localparam dls_cmd_t CMD_CANCEL  = 3'd5;
    localparam dls_cmd_t CMD_RESTART = 3'd6;

    // Four-way result code reported by a stage.
    typedef logic [1:0] dls_rc_t;
    localparam dls_rc_t RC_OK    = 2'd0;  // frame / packet / accepted
    localparam dls_rc_t RC_AGAIN = 2'd1;  // need_input / skipped / need_drain
    localparam dls_rc_t RC_EOS   = 2'd2;
    localparam dls_rc_t RC_ERROR = 2'd3;

    // Next action reported with each result item.
    typedef logic [2:0] dls_action_t;
    localparam dls_action_t ACT_FINISHED = 3'd0;
    localparam dls_action_t ACT_WAIT     = 3'd1;
    localparam dls_action_t ACT_RECEIVE  = 3'd2;
    localparam dls_action_t ACT_SEND_PKT = 3'd3;
    localparam dls_action_t ACT_READ_PKT = 3'd4;
    localparam dls_action_t ACT_FLUSH    = 3'd5;

    // Loop status flags.
    typedef struct packed {
        logic done;
        logic fail;
        logic cancel;
        logic receive_wanted;
        logic packet_waiting;
        logic demux_over;
        logic flush;
    } dls_flags_t;

endpackage

[sv/dls_event_update.sv]
// ----------------------------------------------------------------------------
// dls_event_update: flag update for one event
// Applies an event kind and its result code to the current loop flags.
// ----------------------------------------------------------------------------
module dls_event_update (
    input  dls_pkg::dls_cmd_t   cmd,
    input  dls_pkg::dls_rc_t    result_code,
    input  dls_pkg::dls_flags_t flags,
    output dls_pkg::dls_flags_t flags_next
);
    import dls_pkg::*;

    // Each event kind touches its own subset of the flags.
    always_comb
    begin
        flags_next = flags;
        case (cmd)
            CMD_RECV:
            begin
                case (result_code)
                    RC_OK:
                    begin
                        flags_next.receive_wanted = 1'b1;
                    end
                    RC_AGAIN:
                    begin
                        // Nothing left upstream: the loop has drained.
                        if (flags.demux_over && flags.flush)
                            flags_next.done = 1'b1;
                        else
                            flags_next.receive_wanted = 1'b0;
                    end
                    RC_EOS:
                    begin
                        flags_next.done = 1'b1;
                    end
                    default:
                    begin
                        flags_next.fail = 1'b1;
                        flags_next.done = 1'b1;
                    end
                endcase
            end
            CMD_DEMUX:
            begin
                flags_next.receive_wanted = 1'b0;
                case (result_code)
                    RC_OK:
                    begin
                        flags_next.packet_waiting = 1'b1;
                    end
                    RC_EOS:
                    begin
                        flags_next.demux_over = 1'b1;
                    end
                    RC_ERROR:
                    begin
                        flags_next.demux_over = 1'b1;
                        flags_next.fail       = 1'b1;
                    end
                    default:
                    begin
                        // A skipped packet changes nothing else.
                    end
                endcase
            end
            CMD_PKT:
            begin
                case (result_code)
                    RC_OK:
                    begin
                        flags_next.packet_waiting = 1'b0;
                        flags_next.receive_wanted = 1'b1;
                    end
                    RC_AGAIN:
                    begin
                        flags_next.receive_wanted = 1'b1;
                    end
                    RC_EOS:
                    begin
                        flags_next.packet_waiting = 1'b0;
                        flags_next.done           = 1'b1;
                    end
                    default:
                    begin
                        flags_next.packet_waiting = 1'b0;
                        flags_next.fail           = 1'b1;
                        flags_next.done           = 1'b1;
                    end
                endcase
            end
            CMD_FLUSH:
            begin
                case (result_code)
                    RC_OK:
                    begin
                        flags_next.flush          = 1'b1;
                        flags_next.receive_wanted = 1'b1;
                    end
                    RC_AGAIN:
                    begin
                        flags_next.receive_wanted = 1'b1;
                    end
                    RC_EOS:
                    begin
                        flags_next.flush = 1'b1;
                        flags_next.done  = 1'b1;
                    end
                    default:
                    begin
                        flags_next.fail = 1'b1;
                        flags_next.done = 1'b1;
                    end
                endcase
            end
            CMD_CANCEL:
            begin
                flags_next.cancel = 1'b1;
                flags_next.done   = 1'b1;
            end
            CMD_RESTART:
            begin
                flags_next = '0;
            end
            default:
            begin
                // Poll and the unused kind leave the flags alone.
            end
        endcase
    end

endmodule

[sv/dls_action_pick.sv]
// ----------------------------------------------------------------------------
// dls_action_pick: next-action priority select
// Chooses the next loop action from the updated flags and output capacity.
// ----------------------------------------------------------------------------
module dls_action_pick (
    input  dls_pkg::dls_flags_t  flags,
    input  logic                 output_ready,
    output dls_pkg::dls_action_t action
);
    import dls_pkg::*;

    // Fixed priority, finished first.
    always_comb
    begin
        if (flags.done)
            action = ACT_FINISHED;
        else if (!output_ready)
            action = ACT_WAIT;
        else if (flags.receive_wanted)
            action = ACT_RECEIVE;
        else if (flags.packet_waiting)
            action = ACT_SEND_PKT;
        else if (!flags.demux_over)
            action = ACT_READ_PKT;
        else if (!flags.flush)
            action = ACT_FLUSH;
        else
            action = ACT_RECEIVE;
    end

endmodule

[sv/decode_loop_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// decode_loop_sequencer_unit: demux-and-decode loop sequencer
// Takes one event item per cycle unless stalled and returns next action with status.
// ----------------------------------------------------------------------------
// Each accepted event item yields exactly one result item. Items enter an
// input register, the flag update and action priority run in one short
// combinational step, and the result lands in an output register; the
// flags change when an item moves from the input register to the output
// register. One item per cycle is sustained whenever m_tready is high, and
// the input keeps accepting while a result waits as long as the input
// register is free. Restart clears all flags; events arriving after the
// loop has finished are still applied.
module decode_loop_sequencer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [1:0] result_code, [2] output_ready, [7:3] zero
    input  logic [2:0] s_tuser,  // [2:0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [2:0] next_action, [3] is_finished, [4] is_failed,
                                 // [5] is_cancelled, [6] has_pending_packet,
                                 // [7] flush_done
);
    import dls_pkg::*;

    logic        in_valid_reg;
    dls_cmd_t    in_cmd_reg;
    dls_rc_t     in_rc_reg;
    logic        in_ready_reg;
    logic        out_valid_reg;
    dls_action_t out_action_reg;
    dls_flags_t  flags_reg;
    dls_flags_t  flags_next;
    dls_action_t action_next;
    logic        advance;
    logic        accept;

    // Handshake: the input register drains into the output register
    // whenever the output register is empty or being read.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Flag update and action pick for the item in the input register.
    dls_event_update u_update (
        .cmd         (in_cmd_reg),
        .result_code (in_rc_reg),
        .flags       (flags_reg),
        .flags_next  (flags_next)
    );

    dls_action_pick u_pick (
        .flags        (flags_next),
        .output_ready (in_ready_reg),
        .action       (action_next)
    );

    // Control state: valid bits and loop flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg   <= s_tuser;
            in_rc_reg    <= s_tdata[1:0];
            in_ready_reg <= s_tdata[2];
        end
        if (advance)
            out_action_reg <= action_next;
    end

    // Result item: the action and the flags as they stood after the event.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {flags_reg.flush, flags_reg.packet_waiting, flags_reg.cancel,
                       flags_reg.fail, flags_reg.done, out_action_reg};

    // The finished action is reported exactly when the done flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flags_reg.done == (out_action_reg == ACT_FINISHED)))
    else $error("next_action disagrees with the finished flag");

    // Cancel always finishes the loop, and only restart clears either.
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.cancel |-> flags_reg.done)
    else $error("cancelled without finished");

    // A restart leaves every flag clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == CMD_RESTART)) |=> (flags_reg == '0))
    else $error("restart did not clear the flags");

    // An empty input register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
    else $error("input stalled with empty input register");

endmodule
